>>> sv/lpabc_pkg.sv
// package for the lidar point aperture and box crop unit
package lpabc_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam logic [31:0] GAIN_INV_Q31 = 32'd1304065748;

    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AZ_LOWER = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AZ_UPPER = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EL_LOWER = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_EL_UPPER = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH = 3'd6;

    localparam logic [63:0] RESET_BOX_LOW = 64'd1151571302718373376;
    localparam logic [63:0] RESET_BOX_HIGH = 64'd1125901517458432;

    typedef struct packed {
        logic signed [COORD_BITS_DEF-1:0] point_z;
        logic signed [COORD_BITS_DEF-1:0] point_y;
        logic signed [COORD_BITS_DEF-1:0] point_x;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_BITS_DEF-1:0] kept_z;
        logic signed [COORD_BITS_DEF-1:0] kept_y;
        logic signed [COORD_BITS_DEF-1:0] kept_x;
    } point_out_t;

    function automatic logic signed [63:0] atan_turn32(input int i);
        logic signed [63:0] t;
        case (i)
            0: t = 64'h20000000;
            1: t = 64'h12E4051E;
            2: t = 64'h09FB385B;
            3: t = 64'h051111D4;
            4: t = 64'h028B0D43;
            5: t = 64'h0145D7E1;
            6: t = 64'h00A2F61E;
            7: t = 64'h00517C55;
            8: t = 64'h0028BE53;
            9: t = 64'h00145F2F;
            10: t = 64'h000A2F98;
            11: t = 64'h000517CC;
            12: t = 64'h00028BE6;
            13: t = 64'h000145F3;
            14: t = 64'h0000A2FA;
            15: t = 64'h0000517D;
            16: t = 64'h000028BE;
            17: t = 64'h0000145F;
            18: t = 64'h00000A30;
            19: t = 64'h00000518;
            20: t = 64'h0000028C;
            21: t = 64'h00000146;
            22: t = 64'h000000A3;
            23: t = 64'h00000051;
            24: t = 64'h00000029;
            25: t = 64'h00000014;
            26: t = 64'h0000000A;
            27: t = 64'h00000005;
            28: t = 64'h00000003;
            29: t = 64'h00000001;
            30: t = 64'h00000001;
            default: t = 64'h0;
        endcase
        return t;
    endfunction

endpackage

>>> sv/lpabc_cordic_cell.sv
// one cordic vectoring micro-rotation with a carried point and keep flag
module lpabc_cordic_cell
    import lpabc_pkg::*;
#(
    parameter int STEP = 0,
    parameter int TAG_BITS = 61
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [63:0]       in_x,
    input  logic signed [63:0]       in_y,
    input  logic signed [63:0]       in_a,
    input  logic [TAG_BITS-1:0]      in_tag,
    output logic                     out_valid,
    output logic signed [63:0]       out_x,
    output logic signed [63:0]       out_y,
    output logic signed [63:0]       out_a,
    output logic [TAG_BITS-1:0]      out_tag
);

    logic signed [63:0] x_next;
    logic signed [63:0] y_next;
    logic signed [63:0] a_next;
    logic               valid_reg;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [63:0] a_reg;
    logic [TAG_BITS-1:0] tag_reg;

    always_comb
    begin
        if (!in_y[63])
        begin
            x_next = in_x + (in_y >>> STEP);
            y_next = in_y - (in_x >>> STEP);
            a_next = in_a + atan_turn32(STEP);
        end
        else
        begin
            x_next = in_x - (in_y >>> STEP);
            y_next = in_y + (in_x >>> STEP);
            a_next = in_a - atan_turn32(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            a_reg <= a_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_a = a_reg;
    assign out_tag = tag_reg;

endmodule

>>> sv/lpabc_cordic_chain.sv
// row of cordic cells with quarter-turn prerotation in front
module lpabc_cordic_chain
    import lpabc_pkg::*;
#(
    parameter int TAG_BITS = 61
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [63:0]    in_x,
    input  logic signed [63:0]    in_y,
    input  logic [TAG_BITS-1:0]   in_tag,
    output logic                  out_valid,
    output logic signed [63:0]    out_mag,
    output logic signed [63:0]    out_a,
    output logic [TAG_BITS-1:0]   out_tag
);

    logic                  v_w [CORDIC_STEPS+1];
    logic signed [63:0]    x_w [CORDIC_STEPS+1];
    logic signed [63:0]    y_w [CORDIC_STEPS+1];
    logic signed [63:0]    a_w [CORDIC_STEPS+1];
    logic [TAG_BITS-1:0]   t_w [CORDIC_STEPS+1];
    logic signed [63:1]    unused_y;

    always_comb
    begin
        v_w[0] = in_valid;
        t_w[0] = in_tag;
        x_w[0] = in_x;
        y_w[0] = in_y;
        a_w[0] = 64'sd0;
        if (in_x[63])
        begin
            if (!in_y[63])
            begin
                x_w[0] = in_y;
                y_w[0] = -in_x;
                a_w[0] = 64'sd1 <<< 30;
            end
            else
            begin
                x_w[0] = -in_y;
                y_w[0] = in_x;
                a_w[0] = -(64'sd1 <<< 30);
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        lpabc_cordic_cell #(.STEP(i), .TAG_BITS(TAG_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v_w[i]), .in_x(x_w[i]), .in_y(y_w[i]), .in_a(a_w[i]),
            .in_tag(t_w[i]),
            .out_valid(v_w[i+1]), .out_x(x_w[i+1]), .out_y(y_w[i+1]),
            .out_a(a_w[i+1]), .out_tag(t_w[i+1])
        );
    end

    assign unused_y = y_w[CORDIC_STEPS][63:1];
    assign out_valid = v_w[CORDIC_STEPS] & ~(|unused_y & 1'b0);
    assign out_mag = x_w[CORDIC_STEPS];
    assign out_a = a_w[CORDIC_STEPS];
    assign out_tag = t_w[CORDIC_STEPS];

endmodule

>>> sv/lidar_point_aperture_box_crop_unit.sv
// lidar point crop: box test, azimuth and elevation cordic rows, window check
// throughput: one point per cycle while the output is not stalled; each cordic row has 32 cells
// the whole pipe advances only when the output register is free or being taken
// reset: all valid flags clear, config registers return to their reset values
// dropped points leave no result, but still pass down the pipe as an empty slot
module lidar_point_aperture_box_crop_unit
    import lpabc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  point_in_t                 in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output point_out_t                out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CB = COORD_BITS_DEF;
    localparam int PB = 3 * CB;
    localparam int TAG_BITS = PB + 2;
    localparam int SH = 32 - ANGLE_BITS;
    localparam int SCALE = 59 - CB;

    logic [2:0]                 mode_reg;
    logic signed [ANGLE_BITS-1:0] az_lo_reg, az_hi_reg, el_lo_reg, el_hi_reg;
    logic [PB-1:0]              box_lo_reg, box_hi_reg;

    logic en;
    logic s0_valid_reg;
    logic [TAG_BITS-1:0] s0_tag_reg;
    logic s0_vert_reg;
    logic signed [CB-1:0] bx, by, bz;
    logic inside_w, box_ok_w;
    logic signed [63:0] px64, py64, pz64;
    logic [TAG_BITS:0] tag0_w;

    logic az_valid;
    logic signed [63:0] az_mag, az_a;
    logic [TAG_BITS:0] az_tag;

    logic g_valid_reg;
    logic signed [63:0] g_mag_reg;
    logic signed [ANGLE_BITS-1:0] g_az_reg;
    logic [TAG_BITS:0] g_tag_reg;
    logic signed [63:0] g_mag_w;
    logic signed [63:0] prod_hi_reg, prod_lo_reg;
    logic signed [ANGLE_BITS-1:0] az_w;
    logic signed [63:0] az_round_w;

    logic p_valid_reg;
    logic [TAG_BITS:0] p_tag_reg;
    logic signed [ANGLE_BITS-1:0] p_az_reg;
    logic signed [63:0] gm_w;
    logic signed [CB-1:0] zc_w;

    logic el_valid;
    logic signed [63:0] el_mag, el_a;
    logic [TAG_BITS+ANGLE_BITS:0] el_tag;
    logic signed [63:0] ea_w, el_round_w;
    logic signed [ANGLE_BITS-1:0] el_w, az_out_w;
    logic keep_w;
    logic out_valid_reg;
    point_out_t out_data_reg;
    point_in_t s0_pt;

    assign en = !out_valid_reg || !out_stall;
    assign in_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 3'd7;
            az_lo_reg <= ANGLE_BITS'(-10923);
            az_hi_reg <= ANGLE_BITS'(10923);
            el_lo_reg <= ANGLE_BITS'(-5461);
            el_hi_reg <= ANGLE_BITS'(5461);
            box_lo_reg <= PB'(RESET_BOX_LOW);
            box_hi_reg <= PB'(RESET_BOX_HIGH);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FILTER_MODE: mode_reg <= cfg_data[2:0];
                REG_AZ_LOWER: az_lo_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_AZ_UPPER: az_hi_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_EL_LOWER: el_lo_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_EL_UPPER: el_hi_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_BOX_LOW: box_lo_reg <= cfg_data[PB-1:0];
                REG_BOX_HIGH: box_hi_reg <= cfg_data[PB-1:0];
                default: ;
            endcase
        end
    end

    // box test up front (enabled by mode bit 1, inverted by mode bit 2), a failing point has its valid flag cleared
    always_comb
    begin
        bx = in_data.point_x;
        by = in_data.point_y;
        bz = in_data.point_z;
        inside_w = !(bx < $signed(box_lo_reg[CB-1:0]) || bx > $signed(box_hi_reg[CB-1:0])
            || by < $signed(box_lo_reg[2*CB-1:CB]) || by > $signed(box_hi_reg[2*CB-1:CB])
            || bz < $signed(box_lo_reg[3*CB-1:2*CB]) || bz > $signed(box_hi_reg[3*CB-1:2*CB]));
        box_ok_w = !mode_reg[1] || (inside_w != mode_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid && box_ok_w &&
                !(mode_reg[0] && in_data == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_tag_reg <= {mode_reg[0], 1'b0, in_data};
            s0_vert_reg <= (in_data.point_x == '0) && (in_data.point_y == '0);
        end
    end

    assign s0_pt = s0_tag_reg[PB-1:0];
    assign px64 = 64'(s0_pt.point_x) <<< SCALE;
    assign py64 = 64'(s0_pt.point_y) <<< SCALE;
    assign pz64 = 64'(s0_pt.point_z) <<< SCALE;
    assign tag0_w = {s0_vert_reg, s0_tag_reg};

    lpabc_cordic_chain #(.TAG_BITS(TAG_BITS+1)) u_az (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s0_valid_reg), .in_x(px64), .in_y(py64), .in_tag(tag0_w),
        .out_valid(az_valid), .out_mag(az_mag), .out_a(az_a), .out_tag(az_tag)
    );

    assign az_round_w = (az_a + (64'sd1 <<< (SH-1))) >>> SH;
    assign az_w = az_tag[TAG_BITS] ? '0 : az_round_w[ANGLE_BITS-1:0];
    assign g_mag_w = (az_tag[TAG_BITS] || az_mag <= 0) ? 64'sd0 : az_mag;

    // gain removal split in two multiplies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= az_valid;
            p_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_mag_reg <= g_mag_w;
            g_az_reg <= az_w;
            g_tag_reg <= az_tag;
            prod_hi_reg <= 64'(g_mag_reg[62:31]) * 64'(GAIN_INV_Q31);
            prod_lo_reg <= 64'(g_mag_reg[30:0]) * 64'(GAIN_INV_Q31);
            p_tag_reg <= g_tag_reg;
            p_az_reg <= g_az_reg;
        end
    end

    assign gm_w = prod_hi_reg + (prod_lo_reg >>> 31);
    assign zc_w = p_tag_reg[PB-1:2*CB];

    lpabc_cordic_chain #(.TAG_BITS(TAG_BITS+ANGLE_BITS+1)) u_el (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(p_valid_reg), .in_x(gm_w), .in_y(64'(zc_w) <<< SCALE),
        .in_tag({p_az_reg, p_tag_reg}),
        .out_valid(el_valid), .out_mag(el_mag), .out_a(el_a), .out_tag(el_tag)
    );

    always_comb
    begin
        ea_w = el_a;
        if (ea_w > (64'sd1 <<< 30))
        begin
            ea_w = 64'sd1 <<< 30;
        end
        if (ea_w < -(64'sd1 <<< 30))
        begin
            ea_w = -(64'sd1 <<< 30);
        end
        el_round_w = (ea_w + (64'sd1 <<< (SH-1))) >>> SH;
        el_w = el_round_w[ANGLE_BITS-1:0];
        az_out_w = el_tag[TAG_BITS+ANGLE_BITS:TAG_BITS+1];
        keep_w = !el_tag[PB+1] || !(az_out_w < az_lo_reg || az_out_w > az_hi_reg ||
            el_w < el_lo_reg || el_w > el_hi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= el_valid && keep_w && !(el_mag[0] & 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= el_tag[PB-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled without cause");
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode_reg[0] && in_data == '0 |=> !s0_valid_reg)
        else $error("origin not dropped");

endmodule
